// File: sv/btae_pkg.sv
// Shared types and codes for the boot transfer acknowledge engine.
// Depends on nothing; btae_step and the top level import it.
package btae_pkg;

  // Command codes carried in a request header.
  localparam logic [2:0] CMD_OTHER     = 3'd0;
  localparam logic [2:0] CMD_COMMAND   = 3'd1;
  localparam logic [2:0] CMD_SEND_FILE = 3'd2;
  localparam logic [2:0] CMD_DATA      = 3'd3;
  localparam logic [2:0] CMD_LAST_DATA = 3'd4;
  localparam logic [2:0] CMD_BOOT      = 3'd5;
  // Stored as the previous command after reset so that no request matches.
  localparam logic [2:0] CMD_NONE      = 3'd7;

  // Reply codes.
  localparam logic [1:0] RC_ACK       = 2'd0;
  localparam logic [1:0] RC_BAD_FILE  = 2'd1;
  localparam logic [1:0] RC_TOO_LARGE = 2'd2;
  localparam logic [1:0] RC_RECEIVED  = 2'd3;

  // File selector value for a name that is not recognized.
  localparam logic [1:0] FSEL_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] cookie;
    logic [31:0] argument;
    logic [15:0] payload_len;
    logic [1:0]  file_select;
  } req_t;

  typedef struct packed {
    logic [1:0]  reply_code;
    logic [31:0] reply_cookie;
    logic [31:0] reply_arg;
    logic        boot_request;
    logic        transfer_busy;
  } rsp_t;

endpackage

// File: sv/btae_ifs.sv
// Valid/ready channel interfaces for request headers and replies.
// Standalone; the field widths match the types in btae_pkg.
interface btae_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] cookie;
  logic [31:0] argument;
  logic [15:0] payload_len;
  logic [1:0]  file_select;

  modport source (output valid, command, cookie, argument, payload_len, file_select,
                  input ready);
  modport sink (input valid, command, cookie, argument, payload_len, file_select,
                output ready);
endinterface

interface btae_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_code;
  logic [31:0] reply_cookie;
  logic [31:0] reply_arg;
  logic        boot_request;
  logic        transfer_busy;

  modport source (output valid, reply_code, reply_cookie, reply_arg, boot_request,
                  transfer_busy, input ready);
  modport sink (input valid, reply_code, reply_cookie, reply_arg, boot_request,
                transfer_busy, output ready);
endinterface

// File: sv/btae_step.sv
// Protocol state and per-header decision logic of the acknowledge engine.
// Depends on btae_pkg.
module btae_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  btae_pkg::req_t  req_i,
  output logic            rsp_vld_o,
  output btae_pkg::rsp_t  rsp_o
);
  import btae_pkg::*;

  logic [31:0] prev_cookie_q;
  logic [2:0]  prev_cmd_q;
  logic [31:0] prev_arg_q;
  logic [1:0]  prev_code_q;
  logic [31:0] prev_rarg_q;
  logic        file_open_q, file_open_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] size_q, size_d;
  logic        busy_q, busy_d;

  logic [2:0]  cmd;
  logic        repeat_hit;
  logic [32:0] end_pos;
  logic        send;
  logic        remember;
  logic        boot;
  logic [1:0]  code;
  logic [31:0] rarg;

  always_comb begin
    // Undefined command codes behave like an unhandled command.
    cmd        = (req_i.command > CMD_BOOT) ? CMD_OTHER : req_i.command;
    repeat_hit = (req_i.cookie == prev_cookie_q) && (cmd == prev_cmd_q) &&
                 (req_i.argument == prev_arg_q);
    end_pos    = {1'b0, offset_q} + {17'b0, req_i.payload_len};

    send        = 1'b1;
    remember    = 1'b1;
    boot        = 1'b0;
    code        = RC_ACK;
    rarg        = '0;
    busy_d      = busy_q;
    file_open_d = file_open_q;
    offset_d    = offset_q;
    size_d      = size_q;

    if (repeat_hit) begin
      // Resend the stored reply; nothing else moves.
      remember = 1'b0;
      code     = prev_code_q;
      rarg     = prev_rarg_q;
    end else begin
      case (cmd)
        CMD_COMMAND: begin
          if (req_i.payload_len == '0) begin
            send     = 1'b0;
            remember = 1'b0;
          end
        end
        CMD_SEND_FILE: begin
          busy_d = 1'b1;
          if (req_i.payload_len == '0) begin
            send     = 1'b0;
            remember = 1'b0;
          end else if (req_i.file_select == FSEL_UNKNOWN) begin
            file_open_d = 1'b0;
            code        = RC_BAD_FILE;
          end else begin
            file_open_d = 1'b1;
            size_d      = req_i.argument;
            offset_d    = '0;
            rarg        = req_i.argument;
          end
        end
        CMD_DATA, CMD_LAST_DATA: begin
          busy_d = 1'b1;
          if (!file_open_q) begin
            send     = 1'b0;
            remember = 1'b0;
          end else if (req_i.argument != offset_q) begin
            rarg = offset_q;
          end else if (end_pos > {1'b0, size_q}) begin
            code = RC_TOO_LARGE;
            rarg = req_i.argument;
          end else begin
            offset_d = end_pos[31:0];
            if (cmd == CMD_LAST_DATA) begin
              code   = RC_RECEIVED;
              busy_d = 1'b0;
            end else begin
              send = 1'b0;
            end
          end
        end
        CMD_BOOT: begin
          boot = 1'b1;
        end
        default: begin
          send = 1'b0;
        end
      endcase
    end
  end

  assign rsp_vld_o           = fire_i && send;
  assign rsp_o.reply_code    = code;
  assign rsp_o.reply_cookie  = req_i.cookie;
  assign rsp_o.reply_arg     = rarg;
  assign rsp_o.boot_request  = boot;
  assign rsp_o.transfer_busy = busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cookie_q <= '0;
      prev_cmd_q    <= CMD_NONE;
      prev_arg_q    <= '0;
      prev_code_q   <= RC_ACK;
      prev_rarg_q   <= '0;
      file_open_q   <= 1'b0;
      offset_q      <= '0;
      size_q        <= '0;
      busy_q        <= 1'b0;
    end else if (fire_i) begin
      if (remember) begin
        prev_cookie_q <= req_i.cookie;
        prev_cmd_q    <= cmd;
        prev_arg_q    <= req_i.argument;
        prev_code_q   <= code;
        prev_rarg_q   <= rarg;
      end
      file_open_q <= file_open_d;
      offset_q    <= offset_d;
      size_q      <= size_d;
      busy_q      <= busy_d;
    end
  end

endmodule

// File: sv/boot_transfer_ack_engine.sv
// Top level of the boot transfer acknowledge engine: input register, decision
// stage and reply register. Depends on btae_pkg, btae_ifs and btae_step.

// The engine takes one validated request header per transfer on req_i and
// returns at most one reply per header on rsp_o. A header is captured in an
// input register; once it can move on, it is decided against the stored
// protocol state (last request and reply, open file, write offset, file size,
// busy flag) and its reply, if any, is written to the reply register. The
// sustained rate is one header per clock cycle while rsp_o is ready, set by
// the single decision stage whose result feeds its own state registers. A
// header waits in the input register and its reply in the reply register
// before the reply is presented on rsp_o. A header that causes no reply, such
// as an in-order data chunk, still takes its turn through the decision stage.
// While a reply waits to be taken, one more header can be held in the input
// register; ready on req_i drops only when both are occupied and rsp_o is not
// ready. A repeated request (same cookie, command and argument as the last
// remembered one) gets the stored reply again with boot_request low.
module boot_transfer_ack_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  btae_req_if.sink    req_i,
  btae_rsp_if.source  rsp_o
);
  import btae_pkg::*;

  logic   in_vld_q;
  req_t   in_q;
  logic   rsp_vld_q;
  rsp_t   rsp_q;

  logic   advance;
  logic   step_vld;
  rsp_t   step_rsp;
  logic   req_fire;

  // The held header moves on whenever the reply register is free or is being
  // emptied in this cycle.
  assign advance   = in_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign req_fire  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.command     <= req_i.command;
      in_q.cookie      <= req_i.cookie;
      in_q.argument    <= req_i.argument;
      in_q.payload_len <= req_i.payload_len;
      in_q.file_select <= req_i.file_select;
    end
  end

  btae_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .req_i     (in_q),
    .rsp_vld_o (step_vld),
    .rsp_o     (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= step_vld;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_vld) begin
      rsp_q <= step_rsp;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.reply_code    = rsp_q.reply_code;
  assign rsp_o.reply_cookie  = rsp_q.reply_cookie;
  assign rsp_o.reply_arg     = rsp_q.reply_arg;
  assign rsp_o.boot_request  = rsp_q.boot_request;
  assign rsp_o.transfer_busy = rsp_q.transfer_busy;

  // A held header that cannot move on must stay in the input register intact.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_q))
    else $error("held header lost or changed while stalled");

  // A boot reply is always a plain acknowledge with a zero argument.
  a_boot_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_q.boot_request |-> rsp_q.reply_code == RC_ACK &&
      rsp_q.reply_arg == '0)
    else $error("boot reply carries a wrong code or argument");

endmodule
